// ===== sv/assert_macros.svh =====
// assertion macros for the rtl files
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/int2r_pkg.sv =====
// shared constants, types and digit encoding for the radix digit converter
// depends on nothing; used by int2r_front, int2r_back and integer_to_radix_digits
package int2r_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_Z  = 7'h5A;
  localparam logic [CHAR_W-1:0]  ASCII_NINE     = 7'h39;

  // classification of a queued word
  typedef struct packed {
    logic               bad;
    logic [RADIX_W-1:0] radix;
  } cls_t;

  function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d >= DECIMAL_DIGITS) begin
      return dx - {1'b0, DECIMAL_DIGITS} + ASCII_UPPER_A;
    end
    return dx + ASCII_ZERO;
  endfunction

endpackage

// ===== sv/int2r_front.sv =====
// front end: accepts input words, checks the radix and holds them in a short queue
// depends on int2r_pkg
module int2r_front #(
  parameter int VALUE_WIDTH = int2r_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [VALUE_WIDTH-1:0]              in_value,
  input  logic [int2r_pkg::RADIX_W-1:0]       in_radix,
  output logic                                q_valid,
  input  logic                                q_pop,
  output logic [VALUE_WIDTH-1:0]              q_value,
  output int2r_pkg::cls_t                     q_cls
);

  logic [VALUE_WIDTH-1:0]          val_r [int2r_pkg::QUEUE_DEPTH];
  int2r_pkg::cls_t                 cls_r [int2r_pkg::QUEUE_DEPTH];
  logic [int2r_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [int2r_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [int2r_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  int2r_pkg::cls_t                 in_cls;
  logic                            push;
  logic                            pop;

  always_comb begin
    in_cls.radix = in_radix;
    in_cls.bad   = (in_radix < int2r_pkg::RADIX_MIN) || (in_radix > int2r_pkg::RADIX_MAX);
  end

  assign in_ready = cnt_r != int2r_pkg::QCNT_W'(int2r_pkg::QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_value  = val_r[rd_ptr_r];
  assign q_cls    = cls_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_r[wr_ptr_r] <= in_value;
      cls_r[wr_ptr_r] <= in_cls;
    end
  end

endmodule

// ===== sv/int2r_back.sv =====
// back end: shift-subtract divider by the radix, one digit per division, output register
// depends on int2r_pkg
module int2r_back #(
  parameter int VALUE_WIDTH = int2r_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [VALUE_WIDTH-1:0]            q_value,
  input  int2r_pkg::cls_t                   q_cls,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [int2r_pkg::CHAR_W-1:0]      out_digit_char,
  output logic                              out_last_digit,
  output logic                              out_bad_radix
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int RW    = int2r_pkg::RADIX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]       quo_r, quo_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [RW-1:0]                radix_r, radix_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         bad_r, bad_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [int2r_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_bad_r, out_bad_nxt;
  logic [RW:0]                  rem_sh;
  logic [RW:0]                  rem_sub;
  logic                         ge;
  logic                         load;

  // one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign ge      = rem_sh >= {1'b0, radix_r};
  assign rem_sub = rem_sh - {1'b0, radix_r};

  assign load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          bad_nxt   = q_cls.bad;
          quo_nxt   = q_value;
          radix_nxt = q_cls.radix;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = q_cls.bad ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            out_char_nxt = '0;
            out_last_nxt = 1'b1;
            out_bad_nxt  = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            out_char_nxt = int2r_pkg::ascii_of_digit(rem_r);
            out_last_nxt = quo_r == '0;
            out_bad_nxt  = 1'b0;
            rem_nxt      = '0;
            cnt_nxt      = '0;
            state_nxt    = (quo_r == '0) ? ST_IDLE : ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      quo_r       <= '0;
      radix_r     <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      bad_r       <= bad_nxt;
      quo_r       <= quo_nxt;
      radix_r     <= radix_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;
  assign out_bad_radix  = out_bad_r;

endmodule

// ===== sv/integer_to_radix_digits.sv =====
// Converts a non-negative VALUE_WIDTH-bit integer to ASCII digits in a radix of 2 to 36,
// least significant digit first, one output word per digit, last_digit on the most
// significant one; a radix outside 2 to 36 gives one word with bad_radix and last_digit set.
// Each digit comes from a restoring shift-subtract divider by the radix that computes
// VALUE_WIDTH quotient bits; the remainder then goes to the output register as the digit
// once that register is free, and a bad radix skips the divider. A two-word input queue
// lets new items arrive during a conversion.
// depends on int2r_pkg, int2r_front, int2r_back and assert_macros.svh
`include "assert_macros.svh"

module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = int2r_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VALUE_WIDTH-1:0]            in_value,
  input  logic [int2r_pkg::RADIX_W-1:0]     in_radix,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [int2r_pkg::CHAR_W-1:0]      out_digit_char,
  output logic                              out_last_digit,
  output logic                              out_bad_radix
);

  logic                   q_valid;
  logic                   q_pop;
  logic [VALUE_WIDTH-1:0] q_value;
  int2r_pkg::cls_t        q_cls;

  int2r_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .in_radix (in_radix),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_value  (q_value),
    .q_cls    (q_cls)
  );

  int2r_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_value        (q_value),
    .q_cls          (q_cls),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .out_bad_radix  (out_bad_radix)
  );

  `ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, q_valid)
  `ASSERT_IMP(a_full_has_data, clk, rst_n, !in_ready, q_valid)
  `ASSERT_IMP(a_bad_is_last, clk, rst_n, out_valid && out_bad_radix,
    out_last_digit && (out_digit_char == '0))
  `ASSERT_IMP(a_char_range, clk, rst_n, out_valid && !out_bad_radix,
    ((out_digit_char >= int2r_pkg::ASCII_ZERO) &&
     (out_digit_char <= int2r_pkg::ASCII_NINE)) ||
    ((out_digit_char >= int2r_pkg::ASCII_UPPER_A) &&
     (out_digit_char <= int2r_pkg::ASCII_UPPER_Z)))

endmodule

// ===== dv/integer_to_radix_digits_tb.sv =====
// self-checking testbench for integer_to_radix_digits: directed and random words, random
// idling on both channels, each output word checked against an in-bench digit predictor
// depends on int2r_pkg and the integer_to_radix_digits rtl
module integer_to_radix_digits_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = int2r_pkg::VALUE_WIDTH_DEF;
  localparam int CW          = int2r_pkg::CHAR_W;
  localparam int RW          = int2r_pkg::RADIX_W;
  localparam int TAIL_CYCLES = (VW + 1) * VW + 64;
  localparam int RAND_ITEMS  = 360;
  localparam int STEADY_ITEMS = 60;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CW-1:0] digit_char;
    logic          last_digit;
    logic          bad_radix;
  } digit_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VW-1:0]      in_value = '0;
  logic [RW-1:0]      in_radix = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CW-1:0]      out_digit_char;
  logic               out_last_digit;
  logic               out_bad_radix;

  digit_word_t expected_digits[$];
  digit_word_t got_word;
  digit_word_t want_word;
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;

  integer_to_radix_digits #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit),
    .out_bad_radix (out_bad_radix)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // digits of one accepted word, least significant first
  task automatic predict_digits(input logic [VW-1:0] value,
                                input logic [RW-1:0] radix);
    logic [VW-1:0] quot;
    int            dval;
    int            count;
    digit_word_t   w;
    if (radix < int2r_pkg::RADIX_MIN || radix > int2r_pkg::RADIX_MAX) begin
      w.digit_char = '0;
      w.last_digit = 1'b1;
      w.bad_radix  = 1'b1;
      expected_digits.push_back(w);
      return;
    end
    quot  = value;
    count = 0;
    do begin
      dval = int'(quot % radix);
      quot = quot / radix;
      if (dval >= int'(int2r_pkg::DECIMAL_DIGITS)) begin
        w.digit_char = CW'(dval - int'(int2r_pkg::DECIMAL_DIGITS) +
                           int'(int2r_pkg::ASCII_UPPER_A));
      end else begin
        w.digit_char = CW'(dval + int'(int2r_pkg::ASCII_ZERO));
      end
      w.last_digit = (quot == '0);
      w.bad_radix  = 1'b0;
      expected_digits.push_back(w);
      count++;
    end while (quot != '0 && count < VW);
  endtask

  task automatic send_word(input logic [VW-1:0] value, input logic [RW-1:0] radix);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_radix <= radix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digits(value, radix);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_word('0, 6'd10);
    send_word({VW{1'b1}}, 6'd2);
    send_word({VW{1'b1}}, int2r_pkg::RADIX_MAX);
    send_word('0, int2r_pkg::RADIX_MIN);
    send_word('0, int2r_pkg::RADIX_MAX);
    send_word(VW'(35), 6'd36);
    send_word(VW'(9), 6'd10);
    send_word(VW'(10), 6'd11);
    send_word(VW'(255), 6'd16);
    send_word(VW'(1), 6'd2);
    send_word(VW'(36), 6'd36);
    send_word(VW'(1234567890), 6'd10);
  endtask

  task automatic test_bad_radix();
    send_word('0, 6'd0);
    send_word({VW{1'b1}}, 6'd1);
    send_word({VW{1'b1}}, 6'd37);
    send_word('0, 6'd63);
    send_word(VW'(12345), 6'd63);
    send_word({VW{1'b1}}, 6'd0);
    send_word(VW'(100), 6'd10);
  endtask

  // sender holds off until the block has emptied
  task automatic test_drain_pause();
    send_word({VW{1'b1}}, 6'd3);
    send_word(VW'(7), 6'd40);
    wait_drained();
    send_word(VW'(65535), 6'd16);
    send_word(VW'(0), 6'd7);
    wait_drained();
  endtask

  task automatic send_random_word();
    logic [VW-1:0]      value;
    logic [RW-1:0]      radix;
    longint             pw;
    int                 k;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 0) radix = RW'($urandom_range(0, 1));
      else radix = RW'($urandom_range(37, 63));
    end else begin
      case ($urandom_range(0, 5))
        0:       radix = int2r_pkg::RADIX_MIN;
        1:       radix = int2r_pkg::RADIX_MAX;
        default: radix = RW'($urandom_range(2, 36));
      endcase
    end
    case ($urandom_range(0, 5))
      0: value = VW'($urandom);
      1: value = VW'($urandom);
      2: value = VW'($urandom_range(0, 2000));
      3: begin
        // around a power of the radix
        pw = 1;
        k  = $urandom_range(1, VW);
        if (radix >= int2r_pkg::RADIX_MIN) begin
          while (k > 0 && pw * radix < (64'd1 << VW)) begin
            pw = pw * radix;
            k--;
          end
        end
        value = VW'(pw - longint'($urandom_range(0, 1)));
      end
      4: value = {VW{1'b1}};
      default: value = '0;
    endcase
    send_word(value, radix);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_on = ((i / 50) % 3) != 2;
      send_random_word();
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    for (int i = 0; i < STEADY_ITEMS; i++) begin
      send_random_word();
    end
  endtask

  // receiver stalls
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (rst_n && idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word.digit_char = out_digit_char;
      got_word.last_digit = out_last_digit;
      got_word.bad_radix  = out_bad_radix;
      if (expected_digits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected word: char=%h last=%b bad=%b", got_word.digit_char,
                   got_word.last_digit, got_word.bad_radix);
        end
      end else begin
        want_word = expected_digits.pop_front();
        if (got_word.digit_char !== want_word.digit_char ||
            got_word.last_digit !== want_word.last_digit ||
            got_word.bad_radix !== want_word.bad_radix) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: char exp=%h got=%h last exp=%b got=%b bad exp=%b got=%b",
                     want_word.digit_char, got_word.digit_char, want_word.last_digit,
                     got_word.last_digit, want_word.bad_radix, got_word.bad_radix);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_bad_radix();
    test_drain_pause();
    test_random_mix();
    test_steady_stream();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_digits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
